// ----- rtl/sha256_hash_engine_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine assertion macros
// Shorthand for the concurrent checks that watch the engine's ports.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SHA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SHA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define SHA_ASSERT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Request types, constants, round constants and the round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int BLOCK_BYTES     = 64;
  localparam int LEN_POS         = 56;
  localparam int ROUNDS          = 64;
  localparam int DIGEST_WORDS    = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic        tail;
  } queue_entry_t;

  localparam logic [31:0] HASH_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- rtl/sha256_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message bytes, appends padding and length, and packs 32-bit words.
// ----------------------------------------------------------------------------
module sha256_front import sha256_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  in_req_t      in_req,
  output logic         q_push,
  output queue_entry_t q_entry,
  input  logic         q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ONE  = 2'd1;
  localparam logic [1:0] F_ZERO = 2'd2;
  localparam logic [1:0] F_LEN  = 2'd3;

  localparam logic [5:0] LEN_START = 6'(LEN_POS);
  localparam logic [5:0] LAST_POS  = 6'(BLOCK_BYTES - 1);

  logic [1:0]  fstate;
  logic [5:0]  fill;
  logic [5:0]  fill_next;
  logic [23:0] part;
  logic [63:0] bit_count;
  logic [63:0] len_shift;
  logic        in_fire;
  logic        pad_go;
  logic        inj;
  logic [7:0]  inj_byte;

  assign in_stall  = (fstate != F_IDLE) || q_full;
  assign in_fire   = in_valid && !in_stall;
  assign pad_go    = (fstate != F_IDLE) && !q_full;
  assign fill_next = fill + 6'd1;
  assign len_shift = bit_count >> {~fill[2:0], 3'b000};

  always_comb begin
    inj      = 1'b0;
    inj_byte = in_req.data_byte;
    unique case (fstate)
      F_IDLE: begin
        inj      = in_fire && in_req.byte_present;
        inj_byte = in_req.data_byte;
      end
      F_ONE: begin
        inj      = pad_go;
        inj_byte = PAD_BYTE;
      end
      F_ZERO: begin
        inj      = pad_go;
        inj_byte = 8'h00;
      end
      F_LEN: begin
        inj      = pad_go;
        inj_byte = len_shift[7:0];
      end
      default: begin
        inj = 1'b0;
      end
    endcase
  end

  assign q_push       = inj && (fill[1:0] == 2'b11);
  assign q_entry.word = {part, inj_byte};
  assign q_entry.tail = (fstate == F_LEN) && (fill == LAST_POS);

  always_ff @(posedge clk) begin
    if (inj) begin
      part <= {part[15:0], inj_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate    <= F_IDLE;
      fill      <= '0;
      bit_count <= '0;
    end else begin
      if (inj) begin
        fill <= fill_next;
      end
      if (in_fire && in_req.byte_present) begin
        bit_count <= bit_count + 64'd8;
      end
      unique case (fstate) inside
        F_IDLE: begin
          if (in_fire && in_req.message_end) begin
            fstate <= F_ONE;
          end
        end
        F_ONE, F_ZERO: begin
          if (pad_go) begin
            fstate <= (fill_next == LEN_START) ? F_LEN : F_ZERO;
          end
        end
        F_LEN: begin
          if (pad_go && (fill == LAST_POS)) begin
            fstate    <= F_IDLE;
            bit_count <= '0;
          end
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sha256_queue.sv -----
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short first-in first-out buffer of message words between front and core.
// ----------------------------------------------------------------------------
module sha256_queue import sha256_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output queue_entry_t head,
  output logic         head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  queue_entry_t     slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/sha256_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs one round per cycle while fed, folds blocks into the hash and emits the digest.
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  queue_entry_t q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output out_req_t     out_req
);

  localparam logic [1:0] C_RUN  = 2'd0;
  localparam logic [1:0] C_ADD  = 2'd1;
  localparam logic [1:0] C_EMIT = 2'd2;

  localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
  localparam logic [5:0] LOAD_LAST  = 6'd15;
  localparam logic [2:0] LAST_WORD  = 3'(DIGEST_WORDS - 1);

  logic [1:0]  state;
  logic [5:0]  round;
  logic [2:0]  emit_idx;
  logic        blk_tail;
  logic [31:0] hash  [8];
  logic [31:0] work  [8];
  logic [31:0] sched [16];
  logic [31:0] wx;
  logic [31:0] wx_next;
  logic [31:0] w_cur;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        loading;
  logic        round_go;
  logic        out_load;

  assign loading  = (round[5:4] == 2'b00);
  assign round_go = (state == C_RUN) && (!loading || q_valid);
  assign q_pop    = (state == C_RUN) && loading && q_valid;
  assign w_cur    = loading ? q_head.word : wx;
  assign out_load = (state == C_EMIT) && (!out_valid || !out_stall);

  assign wx_next = small_sigma1(sched[15]) + sched[10] + small_sigma0(sched[2]) + sched[1];
  assign t1 = work[7] + big_sigma1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
            + ROUND_K[round] + w_cur;
  assign t2 = big_sigma0(work[0])
            + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));

  always_ff @(posedge clk) begin
    if (round_go) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= w_cur;
      wx        <= wx_next;
      if (round == LOAD_LAST) begin
        blk_tail <= q_head.tail;
      end
    end
    if (out_load) begin
      out_req.digest_word <= hash[emit_idx];
      out_req.word_number <= emit_idx;
      out_req.last_word   <= (emit_idx == LAST_WORD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_RUN;
      round    <= '0;
      emit_idx <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= HASH_IV[i];
        work[i] <= HASH_IV[i];
      end
    end else begin
      unique case (state)
        C_RUN: begin
          if (round_go) begin
            round   <= round + 6'd1;
            work[7] <= work[6];
            work[6] <= work[5];
            work[5] <= work[4];
            work[4] <= work[3] + t1;
            work[3] <= work[2];
            work[2] <= work[1];
            work[1] <= work[0];
            work[0] <= t1 + t2;
            if (round == LAST_ROUND) begin
              state <= C_ADD;
            end
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
            work[i] <= hash[i] + work[i];
          end
          emit_idx <= '0;
          state    <= blk_tail ? C_EMIT : C_RUN;
        end
        C_EMIT: begin
          if (out_load) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == LAST_WORD) begin
              state <= C_RUN;
              for (int i = 0; i < 8; i++) begin
                hash[i] <= HASH_IV[i];
                work[i] <= HASH_IV[i];
              end
            end
          end
        end
        default: begin
          state <= C_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/sha256_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-serial SHA-256: a front end pads and packs words, a queue decouples
// it from a one-round-per-cycle compression core that emits the digest.
// ----------------------------------------------------------------------------
// Input requests carry one message byte (when byte_present is set) and may
// close the message with message_end; a closing request may carry no byte,
// and sent alone it hashes an empty message. Output requests carry the
// eight digest words in order, word_number 0 first, last_word on the eighth.
// The front end takes at most one byte per cycle and packs four bytes into
// each queued word. After a closing request it holds in_stall high while it
// writes the padding, one byte per cycle (9 to 72 bytes), and longer while
// the queue is full.
// For each 64-byte block the core runs 16 rounds fed from the queue, then 48
// rounds on the expanded schedule, and folds the result into the hash. The
// load rounds wait on the queue for words packed by the front end. After the
// final block is folded in, the eight digest words leave at one per cycle
// while out_stall is low.
// Reset clears the queue, the byte count and the output, and loads the
// initial hash values. While out_stall is high the output word holds, the
// core waits, the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
module sha256_hash_engine import sha256_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  queue_entry_t q_entry;
  queue_entry_t q_head;

  sha256_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .q_full   (q_full)
  );

  sha256_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  sha256_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

// ----- rtl/sha256_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Concurrent checks on the engine's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_assert.svh"

module sha256_checker import sha256_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_req
);

  `SHA_ASSERT_ALWAYS(a_reset_clears_out, rst, !out_valid, "output valid after reset")
  `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_req), "stalled output changed")
  `SHA_ASSERT_NEXT(a_end_stalls, in_valid && !in_stall && in_req.message_end, in_stall, "no padding stall after message end")
  `SHA_ASSERT_NOW(a_last_is_seven, out_valid && out_req.last_word, out_req.word_number == 3'd7, "last word not at position seven")

endmodule

bind sha256_hash_engine sha256_checker u_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Feeds byte requests into the engine and checks every digest word against a
// behavioral SHA-256 in the bench or a pinned digest. A short directed table
// comes first, then random messages of many lengths under varying backpressure.
// ----------------------------------------------------------------------------
module testbench import sha256_pkg::*; ();

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         closes;
    logic         pinned;
    logic [255:0] digest;
  } dir_row_t;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;
  localparam int DIR_COUNT = 16;
  localparam int RANDOM_PER_PHASE = 90;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_stall;
  in_req_t      in_req = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  out_req_t     out_req;
  logic         pin_valid = 1'b0;
  logic [255:0] pin_digest = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int messages_closed = 0;
  int bytes_hashed = 0;
  int words_checked = 0;
  int two_block_pads = 0;
  int longest_message = 0;
  int current_length = 0;

  logic [31:0] chain_words [8];
  logic [7:0]  block_buf [64];
  logic [5:0]  block_fill;
  logic [63:0] message_bits;
  logic [31:0] fresh_digest [8];
  out_req_t    digest_words_due [$];

  sha256_hash_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < 8; i++) chain_words[i] = HASH_IV[i];
    block_fill = '0;
    message_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
             + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
    e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
    chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
  endfunction

  // Returns 1 when the request closes a message; the digest is then in fresh_digest.
  function automatic bit absorb_request(input in_req_t r);
    if (r.byte_present) begin
      block_buf[block_fill] = r.data_byte;
      block_fill = block_fill + 6'd1;
      message_bits = message_bits + 64'd8;
      bytes_hashed++;
      current_length++;
      if (block_fill == 6'd0) compress_block();
    end
    if (!r.message_end) return 1'b0;
    block_buf[block_fill] = PAD_BYTE;
    for (int k = block_fill + 1; k < BLOCK_BYTES; k++) block_buf[k] = 8'h00;
    if (block_fill >= LEN_POS) begin
      two_block_pads++;
      compress_block();
      for (int k = 0; k < BLOCK_BYTES; k++) block_buf[k] = 8'h00;
    end
    for (int k = 0; k < 8; k++) block_buf[63-k] = message_bits[8*k +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) fresh_digest[i] = chain_words[i];
    if (current_length > longest_message) longest_message = current_length;
    current_length = 0;
    messages_closed++;
    restart_chain();
    return 1'b1;
  endfunction

  function automatic void report_mismatch(input string what, input out_req_t want,
                                          input out_req_t got);
    if (mismatches < 10)
      $display("%0t: %s: expected word %h number %0d last %b, got word %h number %0d last %b",
               $realtime, what, want.digest_word, want.word_number, want.last_word,
               got.digest_word, got.word_number, got.last_word);
    mismatches++;
  endfunction

  initial restart_chain();

  always @(posedge clk) begin : scoreboard
    out_req_t want;
    if (!rst && in_valid && !in_stall) begin
      if (absorb_request(in_req)) begin
        for (int i = 0; i < 8; i++) begin
          want.digest_word = pin_valid ? pin_digest[255-32*i -: 32] : fresh_digest[i];
          want.word_number = i[2:0];
          want.last_word = (i == 7);
          digest_words_due.push_back(want);
        end
      end
    end
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (digest_words_due.size() == 0) begin
        report_mismatch("unexpected digest word", '0, out_req);
      end else begin
        want = digest_words_due.pop_front();
        if (out_req.digest_word !== want.digest_word ||
            out_req.word_number !== want.word_number ||
            out_req.last_word !== want.last_word)
          report_mismatch("digest word mismatch", want, out_req);
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  task automatic send_request(input in_req_t r, input logic pin, input logic [255:0] dig);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    pin_valid <= pin;
    pin_digest <= dig;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (r.byte_present || r.message_end) requests_sent++;
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    while (digest_words_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_message();
    int pick;
    int len;
    bit close_alone;
    in_req_t r;
    pick = $urandom_range(99);
    if (pick < 40) len = $urandom_range(8);
    else if (pick < 70) len = $urandom_range(66, 52);
    else if (pick < 90) len = $urandom_range(51, 9);
    else len = $urandom_range(140, 100);
    close_alone = (len == 0) || $urandom_range(1);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(99) < 10) begin
        r.data_byte = 8'($urandom_range(255));
        r.byte_present = 1'b0;
        r.message_end = 1'b0;
        send_request(r, 1'b0, '0);
      end
      r.data_byte = 8'($urandom_range(255));
      r.byte_present = 1'b1;
      r.message_end = !close_alone && (n == len - 1);
      send_request(r, 1'b0, '0);
    end
    if (close_alone) begin
      r.data_byte = 8'($urandom_range(255));
      r.byte_present = 1'b0;
      r.message_end = 1'b1;
      send_request(r, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int phase_start;
    in_req_t r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 70;
    for (int i = 0; i < DIR_COUNT; i++) begin
      r.data_byte = DIR_ROWS[i].data;
      r.byte_present = DIR_ROWS[i].present;
      r.message_end = DIR_ROWS[i].closes;
      send_request(r, DIR_ROWS[i].pinned, DIR_ROWS[i].digest);
    end
    wait_for_digests();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 36 : 0;
      phase_start = requests_sent;
      while (requests_sent - phase_start < RANDOM_PER_PHASE) send_message();
      wait_for_digests();
    end
    repeat (100) @(negedge clk);
    $display("Hashed %0d messages, %0d bytes in %0d requests; longest %0d bytes.",
             messages_closed, bytes_hashed, requests_sent, longest_message);
    $display("Checked %0d digest words; %0d messages needed a second padding block.",
             words_checked, two_block_pads);
    if (mismatches == 0) begin
      $display("sha256_hash_engine verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("sha256_hash_engine verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d digest words outstanding.", digest_words_due.size());
    $display("sha256_hash_engine verification failed");
    $finish;
  end

endmodule
